// ===== src/ks_pkg.sv =====
// Shared types and constants of the knapsack solver.
`timescale 1ns / 1ps
`default_nettype none
package ks_pkg;

	localparam int TOTAL_W = 21;
	localparam int NUM_W   = 6;

	localparam logic KIND_TOTAL = 1'b0;
	localparam logic KIND_ITEM  = 1'b1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_FILL,
		S_DRAIN,
		S_TWAIT,
		S_TCMP,
		S_ETOT,
		S_ENUM
	} ks_state_t;

	// Write-side control of one table column, registered in the cycle after its read was issued.
	typedef struct packed {
		logic fill_s1;
		logic fits_s1;
		logic col0_s1;
	} ks_fill_t;

endpackage
`default_nettype wire

// ===== src/ks_cell.sv =====
// One table row cell: holds the weight and the best-value row of one item.
`timescale 1ns / 1ps
`default_nettype none
module ks_cell #(
	parameter int NCOL = 256,
	parameter int CW   = 22,
	parameter int VW   = 16,
	localparam int CB  = (NCOL > 1) ? $clog2(NCOL) : 1
) (
	input  wire logic             clk,
	input  wire ks_pkg::ks_fill_t ctl,
	input  wire logic             sel,
	input  wire logic             wt_we,
	input  wire logic [7:0]       wt_in,
	input  wire logic [VW-1:0]    val_in,
	input  wire logic [CB-1:0]    ra,
	input  wire logic [CB-1:0]    rb,
	input  wire logic [CB-1:0]    wcol,
	input  wire logic [CW-1:0]    din_a,
	input  wire logic [CW-1:0]    din_b,
	output logic      [CW-1:0]    dout_a,
	output logic      [CW-1:0]    dout_b,
	output logic      [7:0]       wt_out,
	output logic                  diff
);
	import ks_pkg::*;

	logic [CW-1:0] mem_q [NCOL];
	logic [CW-1:0] rd_a_q;
	logic [CW-1:0] rd_b_q;
	logic [7:0]    wt_q;
	logic [CW-1:0] take;
	logic [CW-1:0] best;

	// The neighbor's row arrives as skip value (din_a) and the value at column minus weight.
	always_comb begin
		take = din_b + CW'(val_in);
		if (ctl.col0_s1) begin
			best = '0;
		end else if (ctl.fits_s1 && (take > din_a)) begin
			best = take;
		end else begin
			best = din_a;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.fill_s1 && sel) begin
			mem_q[wcol] <= best;
		end
		rd_a_q <= mem_q[ra];
		rd_b_q <= mem_q[rb];
		if (wt_we && sel) begin
			wt_q <= wt_in;
		end
	end

	assign dout_a = rd_a_q;
	assign dout_b = rd_b_q;
	assign wt_out = wt_q;
	assign diff   = (rd_a_q != din_a);

endmodule
`default_nettype wire

// ===== src/knapsack_01_solver.sv =====
// Top level of the 0/1 knapsack solver: control, trace-back and the chain of row cells.
// Loading: an item fills one table column per cycle through the compare-add of the cell
// that owns the item's row. Solving: each trace step is one memory read, then one
// compare; then one result per cycle while the output is taken.
// Reset clears control state and sets capacity to 255; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
module knapsack_01_solver #(
	parameter int MAX_ITEMS    = 32,
	parameter int MAX_CAPACITY = 255,
	parameter int VALUE_BITS   = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [7:0]  cfg_wdata,     // capacity
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [23:0] s_axis_tdata,  // item_weight[7:0], item_value[23:8]
	input  wire logic        s_axis_tlast,  // item_last
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic      [31:0] m_axis_tdata,  // total_value[20:0], item_number[26:21], overflow[27]
	output logic      [0:0]  m_axis_tuser,  // result_kind
	output logic             m_axis_tlast   // result_last
);
	import ks_pkg::*;

	localparam int NCOL = MAX_CAPACITY + 1;
	localparam int CB   = (NCOL > 1) ? $clog2(NCOL) : 1;
	localparam int IB   = $clog2(MAX_ITEMS + 1);
	localparam int XB   = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
	localparam int CW   = VALUE_BITS + IB;
	localparam int DW   = (CB > 8) ? CB : 8;

	ks_state_t state_q, state_d;

	logic [7:0]            cap_q;
	logic [IB-1:0]         count_q;
	logic                  ovf_q;
	logic                  last_q;
	logic [7:0]            wt_q;
	logic [VALUE_BITS-1:0] val_q;
	logic [CB-1:0]         j_q;
	ks_fill_t              ctl_s1;
	logic [CB-1:0]         col_s1;
	logic [CB-1:0]         rem_q;
	logic [IB-1:0]         item_q;
	logic [IB-1:0]         nc_q;
	logic [IB-1:0]         idx_q;
	logic                  first_q;
	logic [TOTAL_W-1:0]    total_q;
	logic [IB-1:0]         chosen_q [MAX_ITEMS];

	logic                  out_v_q;
	logic                  kind_o_q;
	logic [TOTAL_W-1:0]    total_o_q;
	logic [NUM_W-1:0]      num_o_q;
	logic                  ovf_o_q;
	logic                  last_o_q;

	logic                  accept;
	logic                  store;
	logic                  out_free;
	logic                  ld_out;
	logic                  fill_go;
	logic                  trace_done;
	logic [CB-1:0]         cap_eff;
	logic [CB-1:0]         ra;
	logic [CB-1:0]         rb;
	logic [IB-1:0]         im1;
	logic [7:0]            w_sel;
	logic                  d_sel;
	logic [CB-1:0]         rem_nx;

	logic [CW-1:0]         a_ch [MAX_ITEMS+1];
	logic [CW-1:0]         b_ch [MAX_ITEMS+1];
	logic [7:0]            wt_arr [MAX_ITEMS];
	logic [MAX_ITEMS-1:0]  diff_v;
	logic [MAX_ITEMS-1:0]  sel_v;

	assign accept     = s_axis_tvalid && s_axis_tready;
	assign store      = (count_q < IB'(MAX_ITEMS));
	assign out_free   = !out_v_q || m_axis_tready;
	assign trace_done = (rem_q == '0) || (item_q == '0);
	assign cap_eff    = (32'(cap_q) > 32'(MAX_CAPACITY)) ? CB'(MAX_CAPACITY) : CB'(cap_q);
	assign ra         = (state_q == S_FILL) ? j_q : rem_q;
	assign rb         = j_q - CB'(wt_q);
	assign im1        = item_q - IB'(1);
	assign w_sel      = wt_arr[im1[XB-1:0]];
	assign d_sel      = diff_v[im1[XB-1:0]];
	assign rem_nx     = (DW'(w_sel) <= DW'(rem_q)) ? (rem_q - CB'(w_sel)) : '0;

	// Row zero of the table is all zero and feeds the first cell.
	assign a_ch[0] = '0;
	assign b_ch[0] = '0;

	for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
		assign sel_v[i] = (count_q == IB'(i));
		ks_cell #(
			.NCOL (NCOL),
			.CW   (CW),
			.VW   (VALUE_BITS)
		) u_cell (
			.clk    (clk),
			.ctl    (ctl_s1),
			.sel    (sel_v[i]),
			.wt_we  (accept && store),
			.wt_in  (s_axis_tdata[7:0]),
			.val_in (val_q),
			.ra     (ra),
			.rb     (rb),
			.wcol   (col_s1),
			.din_a  (a_ch[i]),
			.din_b  (b_ch[i]),
			.dout_a (a_ch[i+1]),
			.dout_b (b_ch[i+1]),
			.wt_out (wt_arr[i]),
			.diff   (diff_v[i])
		);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (store) begin
						state_d = S_FILL;
					end else if (s_axis_tlast) begin
						state_d = S_TWAIT;
					end
				end
			end
			S_FILL: begin
				if (j_q == CB'(MAX_CAPACITY)) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_d = last_q ? S_TWAIT : S_IDLE;
			end
			S_TWAIT: begin
				state_d = S_TCMP;
			end
			S_TCMP: begin
				state_d = trace_done ? S_ETOT : S_TWAIT;
			end
			S_ETOT: begin
				if (ld_out) begin
					state_d = (nc_q == '0) ? S_IDLE : S_ENUM;
				end
			end
			S_ENUM: begin
				if (ld_out && (idx_q == nc_q - IB'(1))) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		s_axis_tready = (state_q == S_IDLE);
		fill_go       = (state_q == S_FILL);
		ld_out        = out_free && ((state_q == S_ETOT) || (state_q == S_ENUM));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cap_q   <= 8'd255;
			count_q <= '0;
			ovf_q   <= 1'b0;
			last_q  <= 1'b0;
			j_q     <= '0;
			ctl_s1  <= '0;
			rem_q   <= '0;
			item_q  <= '0;
			nc_q    <= '0;
			idx_q   <= '0;
			first_q <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			ctl_s1.fill_s1 <= fill_go;
			ctl_s1.fits_s1 <= (DW'(wt_q) <= DW'(j_q));
			ctl_s1.col0_s1 <= (j_q == '0);
			if (accept) begin
				if (store) begin
					last_q <= s_axis_tlast;
					j_q    <= '0;
				end else begin
					ovf_q <= 1'b1;
					if (s_axis_tlast) begin
						item_q  <= count_q;
						rem_q   <= cap_eff;
						first_q <= 1'b1;
						nc_q    <= '0;
					end
				end
			end
			if (fill_go && (j_q != CB'(MAX_CAPACITY))) begin
				j_q <= j_q + CB'(1);
			end
			if (state_q == S_DRAIN) begin
				count_q <= count_q + IB'(1);
				if (last_q) begin
					item_q  <= count_q + IB'(1);
					rem_q   <= cap_eff;
					first_q <= 1'b1;
					nc_q    <= '0;
				end
			end
			if (state_q == S_TCMP) begin
				first_q <= 1'b0;
				if (!trace_done) begin
					if (d_sel) begin
						nc_q  <= nc_q + IB'(1);
						rem_q <= rem_nx;
					end
					item_q <= im1;
				end
			end
			if (ld_out) begin
				idx_q <= (state_q == S_ETOT) ? '0 : idx_q + IB'(1);
			end
			if (ld_out && (state_d == S_IDLE)) begin
				count_q <= '0;
				ovf_q   <= 1'b0;
			end
			if (ld_out) begin
				out_v_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			wt_q  <= s_axis_tdata[7:0];
			val_q <= VALUE_BITS'(s_axis_tdata[23:8]);
		end
		col_s1 <= j_q;
		if ((state_q == S_TCMP) && first_q) begin
			total_q <= TOTAL_W'(a_ch[count_q]);
		end
		if ((state_q == S_TCMP) && !trace_done && d_sel) begin
			chosen_q[nc_q[XB-1:0]] <= item_q;
		end
		if (ld_out) begin
			ovf_o_q <= ovf_q;
			if (state_q == S_ETOT) begin
				kind_o_q  <= KIND_TOTAL;
				total_o_q <= total_q;
				num_o_q   <= '0;
				last_o_q  <= (nc_q == '0);
			end else begin
				kind_o_q  <= KIND_ITEM;
				total_o_q <= '0;
				num_o_q   <= NUM_W'(chosen_q[idx_q[XB-1:0]]);
				last_o_q  <= (idx_q == nc_q - IB'(1));
			end
		end
	end

	assign m_axis_tvalid   = out_v_q;
	assign m_axis_tdata    = {4'b0000, ovf_o_q, num_o_q, total_o_q};
	assign m_axis_tuser[0] = kind_o_q;
	assign m_axis_tlast    = last_o_q;

endmodule
`default_nettype wire

// ===== src/ks_check.sv =====
// Port-level checks of the knapsack solver, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module ks_check (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tvalid,
	input wire logic        s_axis_tready,
	input wire logic        s_axis_tlast,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [31:0] m_axis_tdata,
	input wire logic [0:0]  m_axis_tuser,
	input wire logic        m_axis_tlast
);
	import ks_pkg::*;

	// A stalled result keeps its contents until the transfer.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tlast))
		else $error("result changed while stalled");

	// A total result carries no item number.
	a_total_num: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser[0] == KIND_TOTAL) |-> m_axis_tdata[26:21] == 6'd0)
		else $error("total result with an item number");

	// An item result names a real item and carries no total.
	a_item_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser[0] == KIND_ITEM)
			|-> (m_axis_tdata[20:0] == 21'd0) && (m_axis_tdata[26:21] != 6'd0))
		else $error("malformed item result");

	// The final item of a set always starts work, so input is held off next cycle.
	a_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
		else $error("input taken right after the final item");

endmodule

bind knapsack_01_solver ks_check u_ks_check (.*);
`default_nettype wire
